// File: rtl/core/pdhc_pkg.sv
`default_nettype none
// ============================================================================
// pdhc_pkg: shared types and constants for the position dedup hash counter
// Table geometry, word layouts, status and request codes, sequencer states.
// ============================================================================
package pdhc_pkg;

    // table geometry
    localparam int TABLE_SIZE       = 4096;
    localparam int OVERFLOW_ENTRIES = 128;
    localparam int SLOTS            = TABLE_SIZE + OVERFLOW_ENTRIES;
    localparam int SLOT_W           = $clog2(SLOTS);
    localparam int COUNT_WIDTH      = 24;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // game result codes
    localparam logic [1:0] RES_DRAW = 2'd0;
    localparam logic [1:0] RES_WIN  = 2'd1;
    localparam logic [1:0] RES_LOSS = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_NEW        = 3'd0;
    localparam logic [2:0] STAT_UPDATED    = 3'd1;
    localparam logic [2:0] STAT_OVERFLOW   = 3'd2;
    localparam logic [2:0] STAT_ZERO_LOCK  = 3'd3;
    localparam logic [2:0] STAT_READ_VALID = 3'd4;
    localparam logic [2:0] STAT_READ_EMPTY = 3'd5;

    // input word
    typedef struct packed {
        logic        req_type;
        logic [31:0] hash_key;
        logic [31:0] hash_lock;
        logic [31:0] black_men;
        logic [31:0] black_kings;
        logic [31:0] white_men;
        logic [31:0] white_kings;
        logic        side_to_move;
        logic [1:0]  game_result;
        logic [12:0] read_index;
    } in_t;

    // result word
    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] probe_length;
        logic [12:0] longest_probe;
        logic [23:0] invalid_total;
        logic [31:0] entry_black_men;
        logic [31:0] entry_black_kings;
        logic [31:0] entry_white_men;
        logic [31:0] entry_white_kings;
        logic        entry_side;
        logic [23:0] entry_wins;
        logic [23:0] entry_draws;
        logic [23:0] entry_losses;
    } out_t;

    // cleared part of a slot: lock and counters
    typedef struct packed {
        logic [31:0]            lock;
        logic [COUNT_WIDTH-1:0] wins;
        logic [COUNT_WIDTH-1:0] draws;
        logic [COUNT_WIDTH-1:0] losses;
    } tag_t;

    // board part of a slot, never cleared
    typedef struct packed {
        logic [31:0] black_men;
        logic [31:0] black_kings;
        logic [31:0] white_men;
        logic [31:0] white_kings;
        logic        side;
    } body_t;

    // table port control
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic              wr_body;
        logic [SLOT_W-1:0] wr_addr;
    } tbl_ctrl_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// File: rtl/core/position_dedup_hash_counter_top.sv
`default_nettype none
// ============================================================================
// position_dedup_hash_counter_top: linear-probing position table
// Insert or read: lookup, then compare on the one read port, then done; the
// next word is taken once the result is registered. Each extra probed slot
// repeats both. Zero-lock inserts and reads past the table skip to done.
// A result word still waiting on m_ready holds the sequencer in its done state.
// Reset starts a clearing pass over 4224 slots (one slot a cycle), not ready.
// ============================================================================
module position_dedup_hash_counter_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire pdhc_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output pdhc_pkg::out_t      m_data
);
    import pdhc_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    in_t               req_reg, req_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [12:0]       steps_reg, steps_next;
    logic [12:0]       longest_reg, longest_next;
    logic [23:0]       invalid_reg, invalid_next;
    out_t              res_reg, res_next;
    out_t              m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;

    tbl_ctrl_t tbl_ctrl;
    tag_t      wr_tag, rd_tag;
    body_t     wr_body, rd_body;

    logic s_fire, out_free;
    logic idle_read_ok, idle_zero_lock;
    logic chk_hit, chk_last;
    logic [COUNT_WIDTH-1:0] wins_inc, draws_inc, losses_inc;
    out_t base_res;

    pdhc_table u_table (
        .aclk    (aclk),
        .ctrl    (tbl_ctrl),
        .wr_tag  (wr_tag),
        .wr_body (wr_body),
        .rd_tag  (rd_tag),
        .rd_body (rd_body)
    );

    // handshake and decision terms
    assign s_ready        = (state_reg == ST_IDLE);
    assign s_fire         = s_valid && s_ready;
    assign out_free       = !m_valid_reg || m_ready;
    assign idle_read_ok   = (s_data.read_index < 13'(SLOTS));
    assign idle_zero_lock = (s_data.hash_lock == 32'd0);
    assign chk_hit        = (rd_tag.lock == 32'd0) || (rd_tag.lock == req_reg.hash_lock);
    assign chk_last       = (slot_reg == LAST_SLOT);

    // saturating counter bumps
    assign wins_inc   = (rd_tag.wins   == '1) ? rd_tag.wins   : rd_tag.wins   + 1'b1;
    assign draws_inc  = (rd_tag.draws  == '1) ? rd_tag.draws  : rd_tag.draws  + 1'b1;
    assign losses_inc = (rd_tag.losses == '1) ? rd_tag.losses : rd_tag.losses + 1'b1;

    // empty result carrying the global statistics
    always_comb begin
        base_res               = '0;
        base_res.longest_probe = longest_reg;
        base_res.invalid_total = invalid_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.req_type == REQ_READ) begin
                        state_next = idle_read_ok ? ST_LOOKUP : ST_DONE;
                    end else begin
                        state_next = idle_zero_lock ? ST_DONE : ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP: state_next = ST_CHECK;
            ST_CHECK: begin
                if (req_reg.req_type == REQ_READ || chk_hit || chk_last) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // datapath and table control
    always_comb begin
        clr_next     = clr_reg;
        req_next     = req_reg;
        slot_next    = slot_reg;
        steps_next   = steps_reg;
        longest_next = longest_reg;
        invalid_next = invalid_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        tbl_ctrl     = '0;
        wr_tag       = '0;
        wr_body      = '0;

        case (state_reg)
            ST_CLEAR: begin
                // zero one tag per cycle
                tbl_ctrl.wr_en   = 1'b1;
                tbl_ctrl.wr_addr = clr_reg;
                clr_next         = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    req_next   = s_data;
                    steps_next = '0;
                    res_next   = base_res;
                    if (s_data.req_type == REQ_READ) begin
                        slot_next = s_data.read_index;
                        res_next.status = STAT_READ_EMPTY;
                    end else begin
                        slot_next = SLOT_W'(s_data.hash_key % TABLE_SIZE);
                        res_next.status = STAT_ZERO_LOCK;
                    end
                end
            end
            ST_LOOKUP: begin
                tbl_ctrl.rd_en   = 1'b1;
                tbl_ctrl.rd_addr = slot_reg;
            end
            ST_CHECK: begin
                res_next = base_res;
                if (req_reg.req_type == REQ_READ) begin
                    // dump one entry
                    if (rd_tag.lock != 32'd0) begin
                        res_next.status            = STAT_READ_VALID;
                        res_next.entry_black_men   = rd_body.black_men;
                        res_next.entry_black_kings = rd_body.black_kings;
                        res_next.entry_white_men   = rd_body.white_men;
                        res_next.entry_white_kings = rd_body.white_kings;
                        res_next.entry_side        = rd_body.side;
                        res_next.entry_wins        = rd_tag.wins;
                        res_next.entry_draws       = rd_tag.draws;
                        res_next.entry_losses      = rd_tag.losses;
                    end else begin
                        res_next.status = STAT_READ_EMPTY;
                    end
                end else if (chk_hit) begin
                    // store the position and bump its result counter (invalid results: invalid total)
                    wr_tag      = rd_tag;
                    wr_tag.lock = req_reg.hash_lock;
                    case (req_reg.game_result)
                        RES_DRAW: wr_tag.draws  = draws_inc;
                        RES_WIN:  wr_tag.wins   = wins_inc;
                        RES_LOSS: wr_tag.losses = losses_inc;
                        default: begin
                            if (invalid_reg != '1) begin
                                invalid_next = invalid_reg + 1'b1;
                            end
                        end
                    endcase
                    wr_body.black_men   = req_reg.black_men;
                    wr_body.black_kings = req_reg.black_kings;
                    wr_body.white_men   = req_reg.white_men;
                    wr_body.white_kings = req_reg.white_kings;
                    wr_body.side        = req_reg.side_to_move;
                    tbl_ctrl.wr_en      = 1'b1;
                    tbl_ctrl.wr_body    = 1'b1;
                    tbl_ctrl.wr_addr    = slot_reg;
                    if (steps_reg > longest_reg) begin
                        longest_next = steps_reg;
                    end

                    res_next.status = (rd_tag.lock == 32'd0) ? STAT_NEW : STAT_UPDATED;
                    res_next.probe_length      = steps_reg;
                    res_next.longest_probe     = longest_next;
                    res_next.invalid_total     = invalid_next;
                    res_next.entry_black_men   = req_reg.black_men;
                    res_next.entry_black_kings = req_reg.black_kings;
                    res_next.entry_white_men   = req_reg.white_men;
                    res_next.entry_white_kings = req_reg.white_kings;
                    res_next.entry_side        = req_reg.side_to_move;
                    res_next.entry_wins        = wr_tag.wins;
                    res_next.entry_draws       = wr_tag.draws;
                    res_next.entry_losses      = wr_tag.losses;
                end else if (chk_last) begin
                    // ran off the end of the overflow area
                    res_next.status       = STAT_OVERFLOW;
                    res_next.probe_length = steps_reg + 1'b1;
                end else begin
                    // step to the next slot
                    slot_next  = slot_reg + 1'b1;
                    steps_next = steps_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            longest_reg <= '0;
            invalid_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            longest_reg <= longest_next;
            invalid_reg <= invalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        slot_reg   <= slot_next;
        steps_reg  <= steps_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// File: rtl/core/pdhc_table.sv
`default_nettype none
// ============================================================================
// pdhc_table: slot storage of the hash table
// Tag memory (lock and counters) and body memory (boards, side), one write
// port and one registered read port each, sharing addresses.
// ============================================================================
module pdhc_table (
    input  wire logic              aclk,
    input  wire pdhc_pkg::tbl_ctrl_t ctrl,
    input  wire pdhc_pkg::tag_t    wr_tag,
    input  wire pdhc_pkg::body_t   wr_body,
    output pdhc_pkg::tag_t         rd_tag,
    output pdhc_pkg::body_t        rd_body
);
    import pdhc_pkg::*;

    tag_t  tag_mem  [SLOTS];
    body_t body_mem [SLOTS];

    // tag memory
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            tag_mem[ctrl.wr_addr] <= wr_tag;
        end
        if (ctrl.rd_en) begin
            rd_tag <= tag_mem[ctrl.rd_addr];
        end
    end

    // body memory, written only by inserts
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && ctrl.wr_body) begin
            body_mem[ctrl.wr_addr] <= wr_body;
        end
        if (ctrl.rd_en) begin
            rd_body <= body_mem[ctrl.rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/pdhc_checker.sv
`default_nettype none
// ============================================================================
// pdhc_checker: port-level checks of the position dedup hash counter
// Bound to the top level; watches both channels only.
// ============================================================================
module pdhc_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_ready,
    input  wire pdhc_pkg::in_t  s_data,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wire pdhc_pkg::out_t m_data
);
    import pdhc_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one word at a time: busy right after accepting
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted word");

    // reads, zero locks and read misses report no probe
    a_no_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_ZERO_LOCK || m_data.status == STAT_READ_VALID ||
                    m_data.status == STAT_READ_EMPTY) |-> m_data.probe_length == 13'd0)
        else $error("probe length on a non-probing result");

    // a fresh entry has at most one counted result
    a_fresh_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STAT_NEW |->
        ({2'b00, m_data.entry_wins} + {2'b00, m_data.entry_draws} +
         {2'b00, m_data.entry_losses}) <= 26'd1)
        else $error("fresh entry with more than one count");

    // a stored insert never exceeds the longest probe
    a_longest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STAT_NEW || m_data.status == STAT_UPDATED) |->
        m_data.probe_length <= m_data.longest_probe)
        else $error("probe longer than longest probe");

endmodule

bind position_dedup_hash_counter_top pdhc_checker u_pdhc_checker (.*);
`default_nettype wire
